### hw/rtl/multiply_shift_hash_collision_check_assert.svh
// Assertion macros shared by the hash collision checker.
`ifndef MULTIPLY_SHIFT_HASH_COLLISION_CHECK_ASSERT_SVH
`define MULTIPLY_SHIFT_HASH_COLLISION_CHECK_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSHCC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("mshcc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MSHCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("mshcc assertion failed");

`endif

### hw/rtl/mshcc_pkg.sv
`timescale 1ns / 1ps
package mshcc_pkg;

  localparam int unsigned WORD_BITS      = 64;
  localparam int unsigned HALF_BITS      = 32;
  localparam int unsigned MAX_INDEX_BITS = 12;

  // Shift amounts and index widths up to the word size fit in this many bits.
  localparam int unsigned SHAMT_W = 7;

  localparam int unsigned IDX_REG_W = 4;
  localparam int unsigned CFG_IDX_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS = 8'd1;

  localparam logic [WORD_BITS-1:0] MAGIC_RESET      = '0;
  localparam logic [IDX_REG_W-1:0] INDEX_BITS_RESET = 4'd12;

endpackage

### hw/rtl/mshcc_if.sv
`timescale 1ns / 1ps
interface mshcc_item_if;
  logic                                valid;
  logic                                ready;
  logic [mshcc_pkg::WORD_BITS-1:0]     occupancy;
  logic                                last_item;

  modport source (output valid, output occupancy, output last_item, input ready);
  modport sink   (input valid, input occupancy, input last_item, output ready);
endinterface

interface mshcc_result_if;
  logic valid;
  logic ready;
  logic magic_ok;

  modport source (output valid, output magic_ok, input ready);
  modport sink   (input valid, input magic_ok, output ready);
endinterface

interface mshcc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mshcc_pkg::CFG_IDX_W-1:0]     index;
  logic [mshcc_pkg::WORD_BITS-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/multiply_shift_hash_collision_check.sv
`timescale 1ns / 1ps
// Multiply-shift hash collision checker. Within a trial the block takes one occupancy
// word per cycle: a three-stage pipeline forms the 64-bit product from three 32x32
// partial products, selects the slot from the top index bits and then does a
// read-modify-write of the slot table memory, forwarding the previous word when two
// consecutive words hit the same slot. The verdict of a trial is registered onto the result
// channel as its last word leaves stage 3. After that, and after reset,
// the table is cleared by a pass that writes one entry per cycle to all 2**MaxIndexBits
// entries (4096 at the default), during which no occupancy word is accepted; the next
// trial's words are held off until this pass ends. Configuration writes are taken at
// any time and are meant to be made between trials.
module multiply_shift_hash_collision_check #(
  parameter int unsigned MaxIndexBits = mshcc_pkg::MAX_INDEX_BITS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  mshcc_cfg_if.sink      cfg_i,
  mshcc_item_if.sink     in_i,
  mshcc_result_if.source out_o
);

  `include "multiply_shift_hash_collision_check_assert.svh"

  localparam int unsigned WordBits = mshcc_pkg::WORD_BITS;
  localparam int unsigned HalfBits = mshcc_pkg::HALF_BITS;
  localparam int unsigned ShamtW   = mshcc_pkg::SHAMT_W;
  localparam int unsigned Depth    = 1 << MaxIndexBits;

  // Configuration registers.
  logic [WordBits-1:0]                 magic_q;
  logic [mshcc_pkg::IDX_REG_W-1:0]     index_bits_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q      <= mshcc_pkg::MAGIC_RESET;
      index_bits_q <= mshcc_pkg::INDEX_BITS_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == mshcc_pkg::REG_MAGIC) begin
        magic_q <= cfg_i.data;
      end else if (cfg_i.index == mshcc_pkg::REG_INDEX_BITS) begin
        index_bits_q <= cfg_i.data[mshcc_pkg::IDX_REG_W-1:0];
      end
    end
  end

  // Pipeline control.
  logic                    s1_valid_q, s2_valid_q, s3_valid_q;
  logic                    s1_last_q, s2_last_q, s3_last_q;
  logic [WordBits-1:0]     s1_occ_q, s2_occ_q, s3_occ_q;
  logic [MaxIndexBits-1:0] s2_slot_q, s3_slot_q;
  logic                    clr_busy_q;
  logic [MaxIndexBits-1:0] clr_addr_q;
  logic                    out_valid_q, magic_ok_q;
  logic                    collision_q;

  logic adv;
  logic last_busy;
  logic in_fire;
  logic s3_done_last;

  // The whole pipeline holds only when a verdict is ready but the previous one is
  // still waiting to be taken.
  assign adv          = !(s3_valid_q && s3_last_q && out_valid_q && !out_o.ready);
  assign last_busy    = (s1_valid_q && s1_last_q) || (s2_valid_q && s2_last_q) ||
                        (s3_valid_q && s3_last_q);
  assign in_i.ready   = adv && !clr_busy_q && !last_busy;
  assign in_fire      = in_i.valid && in_i.ready;
  assign s3_done_last = adv && s3_valid_q && s3_last_q;

  // Stage 1: partial products of the low 64 bits of occupancy * magic.
  logic [HalfBits-1:0] occ_lo, occ_hi, mag_lo, mag_hi;
  logic [WordBits-1:0] mul_ll;
  logic [HalfBits-1:0] mul_hl, mul_lh;
  logic [WordBits-1:0] pp_ll_q;
  logic [HalfBits-1:0] pp_hl_q, pp_lh_q;

  always_comb begin
    occ_lo = in_i.occupancy[HalfBits-1:0];
    occ_hi = in_i.occupancy[WordBits-1:HalfBits];
    mag_lo = magic_q[HalfBits-1:0];
    mag_hi = magic_q[WordBits-1:HalfBits];
    mul_ll = WordBits'(occ_lo) * WordBits'(mag_lo);
    // Only the low half of the cross products reaches the low 64 product bits.
    mul_hl = occ_hi * mag_lo;
    mul_lh = occ_lo * mag_hi;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_occ_q  <= in_i.occupancy;
      s1_last_q <= in_i.last_item;
      pp_ll_q   <= mul_ll;
      pp_hl_q   <= mul_hl;
      pp_lh_q   <= mul_lh;
    end
  end

  // Stage 2: sum the partial products and take the top index bits (clamped to 1..MaxIndexBits) as the slot.
  logic [HalfBits-1:0] cross_sum;
  logic [WordBits-1:0] product;
  logic [ShamtW-1:0]   ib_ext, eff_bits, shamt;
  logic [WordBits-1:0] shifted;

  always_comb begin
    cross_sum = pp_hl_q + pp_lh_q;
    product   = pp_ll_q + {cross_sum, {HalfBits{1'b0}}};
    ib_ext    = ShamtW'(index_bits_q);
    if (ib_ext == '0) begin
      eff_bits = ShamtW'(1);
    end else if (ib_ext > ShamtW'(MaxIndexBits)) begin
      eff_bits = ShamtW'(MaxIndexBits);
    end else begin
      eff_bits = ib_ext;
    end
    shamt   = ShamtW'(WordBits) - eff_bits;
    shifted = product >> shamt;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_occ_q  <= s1_occ_q;
      s2_last_q <= s1_last_q;
      s2_slot_q <= shifted[MaxIndexBits-1:0];
    end
  end

  // Stage 3: slot table read-modify-write.
  logic [WordBits-1:0] slot_mem [Depth];
  logic [WordBits-1:0] rdata_q;
  logic                fwd_q;
  logic [WordBits-1:0] fwd_occ_q;
  logic                mem_we;
  logic [MaxIndexBits-1:0] mem_waddr;
  logic [WordBits-1:0] mem_wdata;
  logic [WordBits-1:0] held;
  logic                hit;

  // The word in stage 3 writes its slot at the same edge as the next word reads,
  // so a repeated slot takes the occupancy from the stage 3 register instead.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_occ_q  <= s2_occ_q;
      s3_last_q <= s2_last_q;
      s3_slot_q <= s2_slot_q;
      fwd_q     <= s3_valid_q && (s3_slot_q == s2_slot_q);
      fwd_occ_q <= s3_occ_q;
    end
  end

  always_comb begin
    held = fwd_q ? fwd_occ_q : rdata_q;
    hit  = (held != '0) && (held != s3_occ_q);
    if (clr_busy_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = adv && s3_valid_q;
      mem_waddr = s3_slot_q;
      mem_wdata = s3_occ_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rdata_q <= slot_mem[s2_slot_q];
    end
  end

  // Control state: stage valids, collision flag, verdict and clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      collision_q <= 1'b0;
      out_valid_q <= 1'b0;
      magic_ok_q  <= 1'b0;
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
    end else begin
      if (adv) begin
        s1_valid_q <= in_fire;
        s2_valid_q <= s1_valid_q;
        s3_valid_q <= s2_valid_q;
      end
      if (adv && s3_valid_q) begin
        if (s3_last_q) begin
          collision_q <= 1'b0;
        end else if (hit) begin
          collision_q <= 1'b1;
        end
      end
      if (s3_done_last) begin
        out_valid_q <= 1'b1;
        magic_ok_q  <= !(collision_q || hit);
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == {MaxIndexBits{1'b1}}) begin
          clr_busy_q <= 1'b0;
        end
      end else if (s3_done_last) begin
        clr_busy_q <= 1'b1;
        clr_addr_q <= '0;
      end
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.magic_ok = magic_ok_q;

  // A verdict leaves stage 3 only when the result register is free.
  `MSHCC_ASSERT_SAME(a_verdict_slot_free, clk_i, rst_ni, s3_done_last,
                     !out_valid_q || out_o.ready)
  // The clearing pass never overlaps an item in flight.
  `MSHCC_ASSERT_SAME(a_clear_pipe_empty, clk_i, rst_ni, clr_busy_q,
                     !s1_valid_q && !s2_valid_q && !s3_valid_q)
  // Each verdict starts a clearing pass from the first entry.
  `MSHCC_ASSERT_NEXT(a_clear_after_last, clk_i, rst_ni, s3_done_last,
                     clr_busy_q && (clr_addr_q == '0) && !collision_q)

endmodule
